// File: src/timestamped_sample_history_ring_unit_macros.svh
// Assertion macros for the timestamped sample history ring unit.
// Used by the checker that is bound to the top level; no other dependencies.
`ifndef TIMESTAMPED_SAMPLE_HISTORY_RING_UNIT_MACROS_SVH
`define TIMESTAMPED_SAMPLE_HISTORY_RING_UNIT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define TSHR_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the usual clk_i / rst_ni pair.
`define TSHR_ASSERT(lbl, prop, msg) \
  `TSHR_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: src/tshr_pkg.sv
// Shared types and constants for the timestamped sample history ring unit.
// No dependencies; used by the interfaces and by every module but tshr_ram.
`default_nettype none

package tshr_pkg;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned TEMP_W  = 16;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned AGE_W   = 23;
  localparam int unsigned COUNT_W = 9;

  // floor(x / 1000) == (x * DIV_MAGIC) >> DIV_SHIFT for every 32-bit x
  localparam int unsigned MAGIC_W   = 29;
  localparam int unsigned DIV_SHIFT = 38;
  localparam int unsigned PROD_W    = TIME_W + MAGIC_W;
  localparam logic [MAGIC_W-1:0] DIV_MAGIC = 29'd274877907;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_e;

  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic              temp_valid;
    logic [TEMP_W-1:0] setpoint;
    logic [TEMP_W-1:0] temperature;
  } record_t;

  localparam int unsigned RECORD_W = $bits(record_t);

endpackage

`default_nettype wire

// File: src/tshr_if.sv
// Request and response channel interfaces (valid/ready) of the history ring.
// Depends on tshr_pkg for field widths.
`default_nettype none

interface tshr_req_if import tshr_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic        [FUNC_W-1:0]   func;
  logic signed [TEMP_W-1:0]   temperature_in;
  logic signed [TEMP_W-1:0]   setpoint_in;
  logic                       temp_valid_in;
  logic        [INDEX_W-1:0]  chrono_index;
  logic        [TIME_W-1:0]   now_ms;

  modport source (output valid, func, temperature_in, setpoint_in, temp_valid_in,
                  chrono_index, now_ms, input ready);
  modport sink   (input valid, func, temperature_in, setpoint_in, temp_valid_in,
                  chrono_index, now_ms, output ready);
endinterface

interface tshr_rsp_if import tshr_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic signed [TEMP_W-1:0]   temperature_out;
  logic signed [TEMP_W-1:0]   setpoint_out;
  logic                       temp_valid_out;
  logic        [AGE_W-1:0]    age_seconds;
  logic        [COUNT_W-1:0]  record_count;

  modport source (output valid, found, temperature_out, setpoint_out, temp_valid_out,
                  age_seconds, record_count, input ready);
  modport sink   (input valid, found, temperature_out, setpoint_out, temp_valid_out,
                  age_seconds, record_count, output ready);
endinterface

`default_nettype wire

// File: src/timestamped_sample_history_ring_unit.sv
// Each request transaction passes through the registered stages RAM read, age
// subtract and reciprocal multiply by 1/1000 in order. Throughput: one transaction per
// cycle; the pipeline holds as a whole while a result waits to be taken.
// Reset clears write slot, fill count and stage valid bits; the record RAM is not
// cleared, its entries become readable only once written.
// Depends on tshr_pkg, tshr_if and tshr_ram.
`default_nettype none

module timestamped_sample_history_ring_unit import tshr_pkg::*; #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tshr_req_if.sink     req,
  tshr_rsp_if.source   rsp
);

  localparam int unsigned SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned SUM_W  = SLOT_W + INDEX_W + 1;

  func_e                 op;
  logic                  advance;
  logic                  accept;
  logic [SLOT_W-1:0]     write_slot_q, write_slot_d;
  logic [CNT_W-1:0]      fill_count_q, fill_count_d;
  logic                  full;
  logic                  hit;
  logic [SUM_W-1:0]      wrap_sum;
  logic [SUM_W-1:0]      wrap_slot;
  logic [SLOT_W+INDEX_W-1:0] chrono_ext;
  logic [SLOT_W-1:0]     read_slot;
  logic [SLOT_W-1:0]     ram_addr;
  logic                  ram_we, ram_re;
  record_t               wr_rec, rd_rec;
  logic [CNT_W+COUNT_W-1:0] count_ext;

  // stage 1: RAM access in flight
  logic                  s1_valid_q;
  logic                  s1_hit_q;
  logic [TIME_W-1:0]     s1_now_q;
  logic [COUNT_W-1:0]    s1_count_q;
  // stage 2: age difference
  logic                  s2_valid_q;
  logic                  s2_found_q;
  logic [TIME_W-1:0]     s2_diff_q;
  logic [TEMP_W-1:0]     s2_temp_q, s2_setp_q;
  logic                  s2_tvalid_q;
  logic [COUNT_W-1:0]    s2_count_q;
  // stage 3: result register
  logic                  s3_valid_q;
  logic                  s3_found_q;
  logic [PROD_W-1:0]     s3_prod_q;
  logic [TEMP_W-1:0]     s3_temp_q, s3_setp_q;
  logic                  s3_tvalid_q;
  logic [COUNT_W-1:0]    s3_count_q;

  assign advance   = !s3_valid_q || rsp.ready;
  assign req.ready = advance;
  assign accept    = req.valid && advance;
  assign op        = func_e'(req.func);

  // chronological index to physical slot
  assign full       = (fill_count_q == CNT_W'(CAPACITY));
  assign hit        = ({{CNT_W{1'b0}}, req.chrono_index} < {{INDEX_W{1'b0}}, fill_count_q});
  assign wrap_sum   = {{(INDEX_W+1){1'b0}}, write_slot_q}
                    + {{(SLOT_W+1){1'b0}}, req.chrono_index};
  assign wrap_slot  = (wrap_sum >= SUM_W'(CAPACITY)) ? (wrap_sum - SUM_W'(CAPACITY)) : wrap_sum;
  assign chrono_ext = {{SLOT_W{1'b0}}, req.chrono_index};
  assign read_slot  = full ? wrap_slot[SLOT_W-1:0] : chrono_ext[SLOT_W-1:0];

  assign wr_rec.stamp       = req.now_ms;
  assign wr_rec.temp_valid  = req.temp_valid_in;
  assign wr_rec.setpoint    = req.setpoint_in;
  assign wr_rec.temperature = req.temp_valid_in ? req.temperature_in : '0;

  always_comb begin
    write_slot_d = write_slot_q;
    fill_count_d = fill_count_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_addr     = read_slot;
    unique case (op)
      FUNC_ADD: begin
        ram_we   = accept;
        ram_addr = write_slot_q;
        write_slot_d = (write_slot_q == SLOT_W'(CAPACITY - 1)) ? '0
                                                               : write_slot_q + 1'b1;
        if (!full) begin
          fill_count_d = fill_count_q + 1'b1;
        end
      end
      FUNC_READ: begin
        ram_re = accept && hit;
      end
      FUNC_CLEAR: begin
        write_slot_d = '0;
        fill_count_d = '0;
      end
      default: begin
      end
    endcase
  end

  assign count_ext = {{COUNT_W{1'b0}}, fill_count_d};

  tshr_ram #(
    .WIDTH (RECORD_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (wr_rec),
    .rdata_o (rd_rec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_slot_q <= '0;
      fill_count_q <= '0;
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      s3_valid_q   <= 1'b0;
    end else begin
      if (accept) begin
        write_slot_q <= write_slot_d;
        fill_count_q <= fill_count_d;
      end
      if (advance) begin
        s1_valid_q <= accept;
        s2_valid_q <= s1_valid_q;
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_hit_q   <= (op == FUNC_READ) && hit;
      s1_now_q   <= req.now_ms;
      s1_count_q <= count_ext[COUNT_W-1:0];

      // drop the record fields unless the read hit a kept record
      s2_found_q  <= s1_hit_q;
      s2_diff_q   <= s1_hit_q ? (s1_now_q - rd_rec.stamp) : '0;
      s2_temp_q   <= s1_hit_q ? rd_rec.temperature : '0;
      s2_setp_q   <= s1_hit_q ? rd_rec.setpoint : '0;
      s2_tvalid_q <= s1_hit_q && rd_rec.temp_valid;
      s2_count_q  <= s1_count_q;

      s3_found_q  <= s2_found_q;
      s3_prod_q   <= PROD_W'(s2_diff_q) * PROD_W'(DIV_MAGIC);
      s3_temp_q   <= s2_temp_q;
      s3_setp_q   <= s2_setp_q;
      s3_tvalid_q <= s2_tvalid_q;
      s3_count_q  <= s2_count_q;
    end
  end

  assign rsp.valid           = s3_valid_q;
  assign rsp.found           = s3_found_q;
  assign rsp.temperature_out = s3_temp_q;
  assign rsp.setpoint_out    = s3_setp_q;
  assign rsp.temp_valid_out  = s3_tvalid_q;
  assign rsp.age_seconds     = s3_prod_q[DIV_SHIFT +: AGE_W];
  assign rsp.record_count    = s3_count_q;

endmodule

`default_nettype wire

// File: src/tshr_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module tshr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/tshr_checker.sv
// Port-level checker for the history ring response channel, bound to the top.
// Depends on the assertion macro header and tshr_pkg.
`default_nettype none

`include "timestamped_sample_history_ring_unit_macros.svh"

module tshr_checker import tshr_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input logic               found_i,
  input logic [TEMP_W-1:0]  temperature_out_i,
  input logic [TEMP_W-1:0]  setpoint_out_i,
  input logic               temp_valid_out_i,
  input logic [AGE_W-1:0]   age_seconds_i,
  input logic [COUNT_W-1:0] record_count_i
);

  `TSHR_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(found_i) && $stable(record_count_i) && $stable(age_seconds_i), "response changed while stalled")
  `TSHR_ASSERT(a_miss_zero, rsp_valid_i && !found_i |-> temperature_out_i == '0 && setpoint_out_i == '0 && !temp_valid_out_i && age_seconds_i == '0, "record fields set without a hit")
  `TSHR_ASSERT(a_hit_count, rsp_valid_i && found_i |-> record_count_i != '0, "read hit on empty history")
  `TSHR_ASSERT(a_invalid_temp, rsp_valid_i && !temp_valid_out_i |-> temperature_out_i == '0, "invalid temperature not zero")

endmodule

bind timestamped_sample_history_ring_unit tshr_checker u_tshr_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .rsp_valid_i       (rsp.valid),
  .rsp_ready_i       (rsp.ready),
  .found_i           (rsp.found),
  .temperature_out_i (rsp.temperature_out),
  .setpoint_out_i    (rsp.setpoint_out),
  .temp_valid_out_i  (rsp.temp_valid_out),
  .age_seconds_i     (rsp.age_seconds),
  .record_count_i    (rsp.record_count)
);

`default_nettype wire

// File: sim/history_ring_check.sv
`timescale 1ns / 1ps
// Response checker for the timestamped sample history ring unit: mirrors the
// record ring from observed request transactions and compares every response.
// Depends on tshr_pkg and the request/response interfaces in tshr_if.
module history_ring_check import tshr_pkg::*; #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tshr_req_if         req,
  tshr_rsp_if         rsp,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned MS_PER_S   = 1000;
  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic               found;
    logic [TEMP_W-1:0]  temperature;
    logic [TEMP_W-1:0]  setpoint;
    logic               temp_valid;
    logic [AGE_W-1:0]   age;
    logic [COUNT_W-1:0] count;
  } history_reply_t;

  record_t        kept_rec [CAPACITY];
  int unsigned    next_slot;
  int unsigned    held;
  history_reply_t awaited_q [$];

  // Update the mirrored ring and return the reply this operation must produce.
  function automatic history_reply_t apply_history_op(
    input logic [FUNC_W-1:0]  op,
    input logic [TEMP_W-1:0]  temp,
    input logic [TEMP_W-1:0]  setp,
    input logic               tv,
    input logic [INDEX_W-1:0] idx,
    input logic [TIME_W-1:0]  now
  );
    history_reply_t    r;
    int unsigned       slot;
    logic [TIME_W-1:0] elapsed;
    r = '0;
    case (op)
      FUNC_ADD: begin
        kept_rec[next_slot].temperature = tv ? temp : '0;
        kept_rec[next_slot].setpoint    = setp;
        kept_rec[next_slot].temp_valid  = tv;
        kept_rec[next_slot].stamp       = now;
        next_slot = (next_slot == CAPACITY - 1) ? 0 : next_slot + 1;
        if (held < CAPACITY) held++;
      end
      FUNC_READ: begin
        if (idx < held) begin
          // once the ring is full, the oldest record sits at the write slot
          slot = (held < CAPACITY) ? idx : (next_slot + idx) % CAPACITY;
          elapsed       = now - kept_rec[slot].stamp;
          r.found       = 1'b1;
          r.temperature = kept_rec[slot].temperature;
          r.setpoint    = kept_rec[slot].setpoint;
          r.temp_valid  = kept_rec[slot].temp_valid;
          r.age         = AGE_W'(elapsed / MS_PER_S);
        end
      end
      FUNC_CLEAR: begin
        next_slot = 0;
        held      = 0;
      end
      default: ;  // unused code leaves the history alone
    endcase
    r.count = COUNT_W'(held);
    return r;
  endfunction

  function automatic string reply_text(history_reply_t r);
    return $sformatf("found=%0b temp=%0d setpoint=%0d valid=%0b age=%0d count=%0d",
                     r.found, $signed(r.temperature), $signed(r.setpoint),
                     r.temp_valid, r.age, r.count);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    history_reply_t want;
    history_reply_t got;
    if (!rst_ni) begin
      next_slot    = 0;
      held         = 0;
      fail_count_o = 0;
      awaited_q.delete();
    end else begin
      if (req.valid && req.ready) begin
        awaited_q.push_back(apply_history_op(req.func, req.temperature_in, req.setpoint_in,
                                             req.temp_valid_in, req.chrono_index, req.now_ms));
      end
      if (rsp.valid && rsp.ready) begin
        got = {rsp.found, rsp.temperature_out, rsp.setpoint_out, rsp.temp_valid_out,
               rsp.age_seconds, rsp.record_count};
        if (awaited_q.size() == 0) begin
          if (fail_count_o < REPORT_MAX)
            $display("%0t: reply with nothing outstanding: %s", $time, reply_text(got));
          fail_count_o++;
        end else begin
          want = awaited_q.pop_front();
          if (got !== want) begin
            if (fail_count_o < REPORT_MAX) begin
              $display("%0t: reply mismatch", $time);
              $display("  expected %s", reply_text(want));
              $display("  actual   %s", reply_text(got));
            end
            fail_count_o++;
          end
        end
      end
    end
    pending_o = awaited_q.size();
  end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Testbench top for the timestamped sample history ring unit: drives request
// transactions, stalls the response side and reports the verdict.
// Depends on tshr_pkg, tshr_if, the unit itself and history_ring_check.
module tb;
  import tshr_pkg::*;

  localparam int unsigned CAPACITY     = 256;
  localparam int unsigned RANDOM_OPS   = 1350;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic              clk_i;
  logic              rst_ni;
  int unsigned       fail_count;
  int unsigned       pending;
  int unsigned       src_idle_pct;
  int unsigned       dst_idle_pct;
  int unsigned       held_est;  // record count seen from the stimulus side, to aim reads
  logic [TIME_W-1:0] clock_ms;

  tshr_req_if req_if ();
  tshr_rsp_if rsp_if ();

  timestamped_sample_history_ring_unit #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_if),
    .rsp    (rsp_if)
  );

  history_ring_check #(
    .CAPACITY(CAPACITY)
  ) u_history_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req_if),
    .rsp          (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= dst_idle_pct);
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  // Called just after a falling edge; returns just after the falling edge that
  // follows acceptance, with valid still high.
  task automatic issue_op(
    input logic [FUNC_W-1:0]  op,
    input logic [TEMP_W-1:0]  temp,
    input logic [TEMP_W-1:0]  setp,
    input logic               tv,
    input logic [INDEX_W-1:0] idx,
    input logic [TIME_W-1:0]  now
  );
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid          = 1'b1;
    req_if.func           = op;
    req_if.temperature_in = temp;
    req_if.setpoint_in    = setp;
    req_if.temp_valid_in  = tv;
    req_if.chrono_index   = idx;
    req_if.now_ms         = now;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
    if (op == FUNC_ADD && held_est < CAPACITY) held_est++;
    else if (op == FUNC_CLEAR) held_est = 0;
  endtask

  function automatic logic [TEMP_W-1:0] pick_level();
    case ($urandom_range(15))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return '0;
      default: return TEMP_W'($urandom);
    endcase
  endfunction

  task automatic issue_random_op();
    int unsigned         pick;
    logic [FUNC_W-1:0]   op;
    logic [INDEX_W-1:0]  idx;
    logic [TIME_W-1:0]   now;
    pick = $urandom_range(999);
    if (pick < 3)        op = FUNC_CLEAR;
    else if (pick < 6)   op = FUNC_UNUSED;
    else if (pick < 556) op = FUNC_ADD;
    else                 op = FUNC_READ;
    // aim most reads at kept records, the rest anywhere in the index range
    if (held_est > 0 && $urandom_range(9) < 7) idx = INDEX_W'($urandom_range(held_est - 1));
    else idx = INDEX_W'($urandom);
    // time mostly advances in small steps; sometimes jumps, wraps or runs backward
    pick = $urandom_range(19);
    if (pick == 0) begin
      now = $urandom;
    end else begin
      clock_ms += (pick == 1) ? TIME_W'($urandom) : TIME_W'($urandom_range(3000));
      now = clock_ms;
    end
    issue_op(op, pick_level(), pick_level(), 1'($urandom_range(1)), idx, now);
  endtask

  initial begin
    rst_ni                = 1'b0;
    src_idle_pct          = 15;
    dst_idle_pct          = 53;
    held_est              = 0;
    clock_ms              = '0;
    rsp_if.ready          = 1'b0;
    req_if.valid          = 1'b0;
    req_if.func           = FUNC_ADD;
    req_if.temperature_in = '0;
    req_if.setpoint_in    = '0;
    req_if.temp_valid_in  = 1'b0;
    req_if.chrono_index   = '0;
    req_if.now_ms         = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    issue_op(FUNC_READ,  16'h0000, 16'h0000, 1'b0, 8'd0,   32'd0);  // empty history
    issue_op(FUNC_ADD,   16'h7FFF, 16'h8000, 1'b1, 8'd0,   32'hFFFF_FC00);
    issue_op(FUNC_ADD,   16'h8000, 16'h7FFF, 1'b0, 8'hFF,  32'hFFFF_FFFF);  // invalid temp
    issue_op(FUNC_ADD,   16'hFFFF, 16'h0001, 1'b1, 8'd0,   32'd5);
    issue_op(FUNC_READ,  16'h0000, 16'h0000, 1'b0, 8'd0,   32'd1000);  // age across wrap
    issue_op(FUNC_READ,  16'hFFFF, 16'hFFFF, 1'b1, 8'd1,   32'd1000);
    issue_op(FUNC_READ,  16'h0000, 16'h0000, 1'b0, 8'd2,   32'd5);
    issue_op(FUNC_READ,  16'h0000, 16'h0000, 1'b0, 8'd3,   32'd5);  // index equals count
    issue_op(FUNC_READ,  16'h0000, 16'h0000, 1'b0, 8'hFF,  32'd5);
    issue_op(FUNC_READ,  16'h0000, 16'h0000, 1'b0, 8'd0,   32'hFFFF_FBFF);  // largest age
    issue_op(FUNC_UNUSED, 16'h1234, 16'h5678, 1'b1, 8'd1,  32'd7);
    issue_op(FUNC_CLEAR, 16'h4321, 16'h8765, 1'b1, 8'd2,   32'd7);
    issue_op(FUNC_READ,  16'h0000, 16'h0000, 1'b0, 8'd0,   32'd7);  // nothing kept
    issue_op(FUNC_ADD,   16'h0100, 16'hFF00, 1'b1, 8'd0,   32'd0);
    issue_op(FUNC_READ,  16'h0000, 16'h0000, 1'b0, 8'd0,   32'd999);
    issue_op(FUNC_READ,  16'h0000, 16'h0000, 1'b0, 8'd0,   32'd1000);
    issue_op(FUNC_READ,  16'h0000, 16'h0000, 1'b0, 8'd1,   32'd1000);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 15;
          dst_idle_pct = 53;
        end
        1: begin
          src_idle_pct = 53;
          dst_idle_pct = 15;
        end
        default: begin
          src_idle_pct = 0;
          dst_idle_pct = 0;
        end
      endcase
      repeat (RANDOM_OPS / 3) issue_random_op();
    end
    req_if.valid = 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
